[src/vna_pkg.sv]
// Shared types and constants of the vertex normal accumulator.
`default_nettype none
package vna_pkg;

  localparam int NUM_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(NUM_VERTICES);
  localparam int VIDX_W       = 12;
  localparam int AREA_W       = 32;
  localparam int ACC_W        = 40;
  localparam int NRM_W        = 16;
  localparam int SC_W         = 31;           // aligned magnitude, top bit at bit 30
  localparam int SQ_W         = 64;           // sum of three squares
  localparam int LEN_W        = 32;           // square root of the sum
  localparam int QUO_W        = 17;           // quotient bits produced by the divider
  localparam int NUM_W        = 47;           // dividend: magnitude * 2^15 + len / 2

  typedef enum logic {
    OP_TRIANGLE = 1'b0,
    OP_READ     = 1'b1
  } opcode_t;

  // One accumulator entry as it sits in the memory.
  typedef struct packed {
    logic                    mark;
    logic signed [ACC_W-1:0] sum_z;
    logic signed [ACC_W-1:0] sum_y;
    logic signed [ACC_W-1:0] sum_x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] sum_x;
    logic signed [ACC_W-1:0] sum_y;
    logic signed [ACC_W-1:0] sum_z;
  } norm_req_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } norm_rsp_t;

endpackage
`default_nettype wire

[src/vertex_normal_accumulator.sv]
// Top level: per-vertex area accumulator memory with read-modify-write control.
//
//   channel | direction | word
//   in_     | input     | opcode, vertex_a/b/c, area_x/y/z
//   out_    | output    | normal_x/y/z, zero_length, saturated
//
// A triangle word holds the input until its three corner updates are done; they
// overlap on the one read port and one write port of the memory.
// A read word holds the input until the normalizer's result is loaded; a nonzero sum
// first passes bit-serial alignment, a 32-step square root and three 17-step divisions.
// After reset a clearing pass zeroes the memory before any word is taken.
// A finished result waits in the output register; a new word is taken meanwhile.
`default_nettype none
module vertex_normal_accumulator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_a,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_b,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_c,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_x,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_y,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [vna_pkg::NRM_W-1:0]    out_normal_x,
  output logic signed      [vna_pkg::NRM_W-1:0]    out_normal_y,
  output logic signed      [vna_pkg::NRM_W-1:0]    out_normal_z,
  output logic                                     out_zero_length,
  output logic                                     out_saturated
);
  import vna_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TRI   = 6'b000100,
    S_RD0   = 6'b001000,
    S_RD1   = 6'b010000,
    S_NORM  = 6'b100000
  } state_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_add(logic signed [ACC_W-1:0] acc,
                                   logic signed [AREA_W-1:0] add);
    logic signed [ACC_W:0] s;
    sat_t                  r;
    s = {acc[ACC_W-1], acc} + (ACC_W + 1)'(add);
    r.ovf = s[ACC_W] != s[ACC_W-1];
    if (!r.ovf) begin
      r.val = s[ACC_W-1:0];
    end else if (s[ACC_W]) begin
      r.val = {1'b1, {(ACC_W - 1){1'b0}}};
    end else begin
      r.val = {1'b0, {(ACC_W - 1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic idx_ok(logic [VIDX_W-1:0] idx);
    return 32'(idx) < 32'(NUM_VERTICES);
  endfunction

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r;
  logic [1:0]               phase_r;
  logic [VIDX_W-1:0]        va_r, vb_r, vc_r;
  logic signed [AREA_W-1:0] ax_r, ay_r, az_r;
  logic                     fwd_hit_r;
  entry_t                   fwd_data_r;
  logic                     mark_r;
  logic                     out_valid_r;
  logic signed [NRM_W-1:0]  onx_r, ony_r, onz_r;
  logic                     ozero_r, osat_r;

  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  entry_t                   ram_wdata, ram_rdata;
  logic [VIDX_W-1:0]        rd_idx, wr_idx;
  entry_t                   operand, updated;
  sat_t                     sx, sy, sz;
  norm_req_t                nreq;
  norm_rsp_t                nrsp;
  logic                     out_free, out_load, nack;

  vna_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .ack   (nack),
    .rsp   (nrsp)
  );

  // A read issued in the cycle the same entry is written sees the old data, so
  // the written word is carried along and takes its place.
  assign operand = fwd_hit_r ? fwd_data_r : ram_rdata;

  always_comb begin
    case (phase_r)
      2'd0:    rd_idx = va_r;
      2'd1:    rd_idx = vb_r;
      default: rd_idx = vc_r;
    endcase
    case (phase_r)
      2'd1:    wr_idx = va_r;
      2'd2:    wr_idx = vb_r;
      default: wr_idx = vc_r;
    endcase

    sx = sat_add(operand.sum_x, ax_r);
    sy = sat_add(operand.sum_y, ay_r);
    sz = sat_add(operand.sum_z, az_r);
    updated.sum_x = sx.val;
    updated.sum_y = sy.val;
    updated.sum_z = sz.val;
    updated.mark  = operand.mark | sx.ovf | sy.ovf | sz.ovf;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ADDR_W'(wr_idx);
    ram_raddr = ADDR_W'(rd_idx);
    ram_wdata = updated;
    nreq      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_TRI: begin
        ram_re = (phase_r != 2'd3) && idx_ok(rd_idx);
        ram_we = (phase_r != 2'd0) && idx_ok(wr_idx);
      end
      S_RD0: begin
        ram_re    = idx_ok(va_r);
        ram_raddr = ADDR_W'(va_r);
      end
      S_RD1: begin
        ram_we     = idx_ok(va_r);
        ram_waddr  = ADDR_W'(va_r);
        ram_wdata  = '0;
        nreq.start = 1'b1;
        if (idx_ok(va_r)) begin
          nreq.sum_x = operand.sum_x;
          nreq.sum_y = operand.sum_y;
          nreq.sum_z = operand.sum_z;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_NORM) && nrsp.done && out_free;
  assign nack     = out_load;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == ADDR_W'(NUM_VERTICES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == OP_READ) ? S_RD0 : S_TRI;
        end
      end
      S_TRI:   if (phase_r == 2'd3) state_nxt = S_IDLE;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_NORM;
      S_NORM:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      phase_r     <= '0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fwd_hit_r <= ram_we && ram_re && (ram_waddr == ram_raddr);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (state_r == S_TRI) begin
        phase_r <= phase_r + 2'd1;
      end else begin
        phase_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (state_r == S_IDLE && in_valid) begin
      va_r <= in_vertex_a;
      vb_r <= in_vertex_b;
      vc_r <= in_vertex_c;
      ax_r <= in_area_x;
      ay_r <= in_area_y;
      az_r <= in_area_z;
    end
    if (state_r == S_RD1) begin
      mark_r <= idx_ok(va_r) && operand.mark;
    end
    if (out_load) begin
      onx_r   <= nrsp.nrm_x;
      ony_r   <= nrsp.nrm_y;
      onz_r   <= nrsp.nrm_z;
      ozero_r <= nrsp.zero;
      osat_r  <= mark_r;
    end
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_normal_x    = onx_r;
  assign out_normal_y    = ony_r;
  assign out_normal_z    = onz_r;
  assign out_zero_length = ozero_r;
  assign out_saturated   = osat_r;

endmodule
`default_nettype wire

[src/vna_ram.sv]
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/vna_norm.sv]
// Sequential normalizer: alignment, sum of squares, square root and three divisions.
`default_nettype none
module vna_norm (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vna_pkg::norm_req_t req,
  input  wire logic             ack,
  output vna_pkg::norm_rsp_t    rsp
);
  import vna_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_ALIGN = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  localparam logic [NRM_W-1:0] NRM_MAX = NRM_W'((1 << (NRM_W - 1)) - 1);

  nstate_t                 state_r, state_nxt;
  logic [ACC_W-1:0]        mag_r [3];
  logic [2:0]              neg_r;
  logic [1:0]              comp_r;
  logic [4:0]              cnt_r;
  logic [2*SC_W-1:0]       prod_r;
  logic [SQ_W-1:0]         acc_r;
  logic [SQ_W-1:0]         x_r;
  logic [SQ_W-1:0]         res_r;
  logic [SQ_W-1:0]         bit_r;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W:0]          rem_r;
  logic [QUO_W-1:0]        nlo_r;
  logic [QUO_W-1:0]        quo_r;
  logic                    load_r;
  logic                    zero_r;
  logic signed [NRM_W-1:0] nrm_r [3];

  logic [ACC_W-1:0]        orv;
  logic [SC_W-1:0]         sc [3];
  logic [SC_W-1:0]         sel_sc;
  logic [SQ_W-1:0]         rt_sum;
  logic                    rt_ge;
  logic [SQ_W-1:0]         res_next;
  logic [NUM_W-1:0]        num;
  logic [LEN_W:0]          r2;
  logic                    div_ge;
  logic [QUO_W-1:0]        qfull;
  logic [NRM_W-1:0]        qcap;
  logic                    sel_neg;
  logic [ACC_W-1:0]        mag_in [3];
  logic                    in_zero;

  always_comb begin
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    for (int i = 0; i < 3; i++) begin
      sc[i] = mag_r[i][ACC_W-1 -: SC_W];
    end
    case (comp_r)
      2'd0:    begin sel_sc = sc[0]; sel_neg = neg_r[0]; end
      2'd1:    begin sel_sc = sc[1]; sel_neg = neg_r[1]; end
      default: begin sel_sc = sc[2]; sel_neg = neg_r[2]; end
    endcase

    rt_sum   = res_r + bit_r;
    rt_ge    = x_r >= rt_sum;
    res_next = rt_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

    num    = NUM_W'({sel_sc, 15'b0}) + NUM_W'(len_r >> 1);
    r2     = {rem_r[LEN_W-1:0], nlo_r[QUO_W-1]};
    div_ge = r2 >= {1'b0, len_r};
    qfull  = {quo_r[QUO_W-2:0], div_ge};
    qcap   = (qfull > QUO_W'(NRM_MAX)) ? NRM_MAX : qfull[NRM_W-1:0];

    mag_in[0] = req.sum_x[ACC_W-1] ? ACC_W'(-req.sum_x) : ACC_W'(req.sum_x);
    mag_in[1] = req.sum_y[ACC_W-1] ? ACC_W'(-req.sum_y) : ACC_W'(req.sum_y);
    mag_in[2] = req.sum_z[ACC_W-1] ? ACC_W'(-req.sum_z) : ACC_W'(req.sum_z);
    in_zero   = (mag_in[0] | mag_in[1] | mag_in[2]) == '0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE:  if (req.start) state_nxt = in_zero ? N_DONE : N_ALIGN;
      N_ALIGN: if (orv[ACC_W-1]) state_nxt = N_SQ;
      N_SQ:    if (comp_r == 2'd3) state_nxt = N_SQRT;
      N_SQRT:  if (cnt_r == '0) state_nxt = N_DIV;
      N_DIV:   if (!load_r && cnt_r == '0 && comp_r == 2'd2) state_nxt = N_DONE;
      N_DONE:  if (ack) state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (req.start) begin
          mag_r  <= mag_in;
          neg_r  <= {req.sum_z[ACC_W-1], req.sum_y[ACC_W-1], req.sum_x[ACC_W-1]};
          zero_r <= in_zero;
          for (int i = 0; i < 3; i++) begin
            nrm_r[i] <= '0;
          end
        end
      end
      N_ALIGN: begin
        // Shift all three until the largest has its top bit at the word's top.
        if (!orv[ACC_W-1]) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
        comp_r <= '0;
        acc_r  <= '0;
      end
      N_SQ: begin
        prod_r <= sel_sc * sel_sc;
        if (comp_r != 2'd0) begin
          acc_r <= acc_r + SQ_W'(prod_r);
        end
        comp_r <= comp_r + 2'd1;
        x_r    <= acc_r + SQ_W'(prod_r);
        res_r  <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
        cnt_r  <= 5'd31;
      end
      N_SQRT: begin
        if (rt_ge) begin
          x_r <= x_r - rt_sum;
        end
        res_r  <= res_next;
        bit_r  <= bit_r >> 2;
        cnt_r  <= cnt_r - 5'd1;
        len_r  <= LEN_W'(res_next);
        comp_r <= '0;
        load_r <= 1'b1;
      end
      N_DIV: begin
        if (load_r) begin
          rem_r  <= (LEN_W + 1)'(num[NUM_W-1:QUO_W]);
          nlo_r  <= num[QUO_W-1:0];
          quo_r  <= '0;
          cnt_r  <= 5'(QUO_W - 1);
          load_r <= 1'b0;
        end else begin
          if (div_ge) begin
            rem_r <= r2 - {1'b0, len_r};
          end else begin
            rem_r <= r2;
          end
          nlo_r <= nlo_r << 1;
          quo_r <= qfull;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            nrm_r[comp_r] <= sel_neg ? -$signed(qcap) : $signed(qcap);
            comp_r        <= comp_r + 2'd1;
            load_r        <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done  = state_r == N_DONE;
  assign rsp.zero  = zero_r;
  assign rsp.nrm_x = nrm_r[0];
  assign rsp.nrm_y = nrm_r[1];
  assign rsp.nrm_z = nrm_r[2];

endmodule
`default_nettype wire

[src/vna_checker.sv]
// Port-level checks on the vertex normal accumulator, bound to the top level.
`default_nettype none
module vna_port_checks (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              in_opcode,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [vna_pkg::NRM_W-1:0]  out_normal_x,
  input wire logic signed [vna_pkg::NRM_W-1:0]  out_normal_y,
  input wire logic signed [vna_pkg::NRM_W-1:0]  out_normal_z,
  input wire logic                              out_zero_length,
  input wire logic                              out_saturated
);
  import vna_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normal_x) &&
      $stable(out_normal_y) && $stable(out_normal_z) &&
      $stable(out_zero_length) && $stable(out_saturated))
    else $error("stalled result word changed");

  // The block works on one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in the cycle after an accepted word");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("zero-length result carries a nonzero normal");

  // A unit normal always has a large component.
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_length |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("normalized result is all zero");

  // An accepted read keeps the input stalled while it reads and clears its memory entry.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_READ |=> ##1 in_stall)
    else $error("read word did not keep the input stalled");

endmodule

bind vertex_normal_accumulator vna_port_checks u_vna_checker (.*);
`default_nettype wire

[tb/sv/vna_checker.sv]
// Checker for the vertex normal accumulator: watches both channels, predicts and compares.
module vna_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic                                in_opcode,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_a,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_b,
  input  wire logic        [vna_pkg::VIDX_W-1:0]   in_vertex_c,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_x,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_y,
  input  wire logic signed [vna_pkg::AREA_W-1:0]   in_area_z,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [vna_pkg::NRM_W-1:0]    out_normal_x,
  input  wire logic signed [vna_pkg::NRM_W-1:0]    out_normal_y,
  input  wire logic signed [vna_pkg::NRM_W-1:0]    out_normal_z,
  input  wire logic                                out_zero_length,
  input  wire logic                                out_saturated,
  output int                                       fail_count,
  output int                                       pending_normals,
  output int                                       normals_seen,
  output int                                       saturated_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    zero;
    logic                    sat;
  } normal_t;

  localparam longint SUM_MAX = (64'sd1 <<< 39) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 39);

  longint  acc_x [NUM_VERTICES];
  longint  acc_y [NUM_VERTICES];
  longint  acc_z [NUM_VERTICES];
  bit      clamp_mark [NUM_VERTICES];
  normal_t expected_normals[$];

  assign pending_normals = expected_normals.size();

  function automatic longint clamp_add(longint a, longint b, inout bit ovf);
    longint r;
    r = a + b;
    if (r > SUM_MAX) begin ovf = 1; return SUM_MAX; end
    if (r < SUM_MIN) begin ovf = 1; return SUM_MIN; end
    return r;
  endfunction

  function automatic void add_to_vertex(int v, longint x, longint y, longint z);
    bit ovf;
    ovf = 0;
    acc_x[v] = clamp_add(acc_x[v], x, ovf);
    acc_y[v] = clamp_add(acc_y[v], y, ovf);
    acc_z[v] = clamp_add(acc_z[v], z, ovf);
    if (ovf) clamp_mark[v] = 1;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] align(bit [63:0] a, int bl);
    if (bl > 31) return a >> (bl - 31);
    return a << (31 - bl);
  endfunction

  function automatic logic signed [NRM_W-1:0] unit_part(longint s, bit [63:0] a,
                                                        bit [63:0] len);
    bit [63:0] q;
    q = (a * 64'd32768 + (len >> 1)) / len;
    if (q > 32767) q = 32767;
    if (s < 0) q = -q;
    return q[NRM_W-1:0];
  endfunction

  function automatic normal_t read_and_clear(int v);
    normal_t   n;
    longint    sx, sy, sz;
    bit [63:0] mx, my, mz, m, len;
    int        bl;
    n = '0;
    n.zero = 1;
    sx = acc_x[v]; sy = acc_y[v]; sz = acc_z[v];
    n.sat = clamp_mark[v];
    acc_x[v] = 0; acc_y[v] = 0; acc_z[v] = 0; clamp_mark[v] = 0;
    mx = sx < 0 ? -sx : sx;
    my = sy < 0 ? -sy : sy;
    mz = sz < 0 ? -sz : sz;
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    if (m == 0) return n;
    bl = 0;
    while (bl < 63 && (m >> bl) != 0) bl++;
    mx = align(mx, bl); my = align(my, bl); mz = align(mz, bl);
    len = int_sqrt(mx * mx + my * my + mz * mz);
    if (len == 0) return n;
    n.nx = unit_part(sx, mx, len);
    n.ny = unit_part(sy, my, len);
    n.nz = unit_part(sz, mz, len);
    n.zero = 0;
    return n;
  endfunction

  always @(posedge clk) begin
    normal_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; clamp_mark[i] = 0;
      end
      expected_normals.delete();
      fail_count <= 0;
      normals_seen <= 0;
      saturated_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_normal_x, out_normal_y, out_normal_z, out_zero_length, out_saturated};
        normals_seen <= normals_seen + 1;
        if (out_saturated) saturated_seen <= saturated_seen + 1;
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d z=%0d zero=%0b sat=%0b", $time,
                   got.nx, got.ny, got.nz, got.zero, got.sat);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_normals.pop_front();
          if (got !== want) begin
            $display("%0t: expected x=%0d y=%0d z=%0d zero=%0b sat=%0b", $time,
                     want.nx, want.ny, want.nz, want.zero, want.sat);
            $display("%0t:   actual x=%0d y=%0d z=%0d zero=%0b sat=%0b", $time,
                     got.nx, got.ny, got.nz, got.zero, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_READ) begin
          expected_normals.push_back(read_and_clear(in_vertex_a));
        end else begin
          add_to_vertex(in_vertex_a, in_area_x, in_area_y, in_area_z);
          add_to_vertex(in_vertex_b, in_area_x, in_area_y, in_area_z);
          add_to_vertex(in_vertex_c, in_area_x, in_area_y, in_area_z);
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top: drives triangle and read words into the accumulator and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_opcode;
  logic        [VIDX_W-1:0] in_vertex_a, in_vertex_b, in_vertex_c;
  logic signed [AREA_W-1:0] in_area_x, in_area_y, in_area_z;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [NRM_W-1:0]  out_normal_x, out_normal_y, out_normal_z;
  logic                     out_zero_length, out_saturated;
  int                       fail_count, pending_normals, normals_seen, saturated_seen;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_receiver;
  int  quiet_cycles;
  int  words_sent;

  vertex_normal_accumulator u_dut (.*);

  vna_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (rst_n);
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  function automatic logic [VIDX_W-1:0] pick_vertex();
    // Mostly a small pool so sums build up and reads find them.
    if ($urandom_range(9) < 8) return VIDX_W'($urandom_range(15));
    return VIDX_W'($urandom_range(4095));
  endfunction

  function automatic logic signed [AREA_W-1:0] pick_area();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic op, logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b,
                           logic [VIDX_W-1:0] c, logic signed [AREA_W-1:0] x,
                           logic signed [AREA_W-1:0] y, logic signed [AREA_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_vertex_c <= c;
    in_area_x   <= x;
    in_area_y   <= y;
    in_area_z   <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_triangle(logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b,
                               logic [VIDX_W-1:0] c, logic signed [AREA_W-1:0] x,
                               logic signed [AREA_W-1:0] y, logic signed [AREA_W-1:0] z);
    send_word(OP_TRIANGLE, a, b, c, x, y, z);
  endtask

  task automatic send_read(logic [VIDX_W-1:0] v);
    send_word(OP_READ, v, VIDX_W'($urandom), VIDX_W'($urandom), $urandom, $urandom,
              $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_normals != 0) @(posedge clk);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7)
        send_triangle(pick_vertex(), pick_vertex(), pick_vertex(),
                      pick_area(), pick_area(), pick_area());
      else
        send_read(pick_vertex());
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_TRIANGLE;
    in_vertex_a = 0; in_vertex_b = 0; in_vertex_c = 0;
    in_area_x = 0; in_area_y = 0; in_area_z = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, extremes, repeated corners, saturation, single axes.
    send_read(12'd0);
    send_read(12'd4095);
    send_triangle(12'd1, 12'd1, 12'd1, 32'sh7fffffff, 32'sh80000000, 32'sd1);
    send_read(12'd1);
    for (int i = 0; i < 140; i++)
      send_triangle(12'd2, 12'd2, 12'd4095, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_read(12'd2);
    send_read(12'd4095);
    send_triangle(12'd3, 12'd4, 12'd5, 32'sd0, 32'sd0, -32'sd1);
    send_triangle(12'd6, 12'd6, 12'd7, 32'sd65536, 32'sd0, 32'sd0);
    send_triangle(12'd7, 12'd8, 12'd8, 32'sd3, 32'sd4, -32'sd12);
    send_read(12'd3);
    send_read(12'd6);
    send_read(12'd7);
    send_read(12'd8);
    send_triangle(12'hAAA, 12'h555, 12'hFFF, 32'shAAAAAAAA, 32'sh55555555, 32'shFFFFFFFF);
    send_read(12'hAAA);
    send_read(12'h555);
    send_read(12'hFFF);
    send_read(12'd3);
    drain();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 60 : 12) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 60 : 12) : 0;
      random_words(350);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_words(40);
    drain();

    // Long hold-off on the receiver while reads keep coming.
    fork
      begin
        hold_receiver = 1;
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 60; i++) send_read(pick_vertex());
    join
    random_words(180);
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d words; %0d normals checked, %0d with the saturation flag",
             words_sent, normals_seen, saturated_seen);
    $display("idle mixes: none, sender 60%%, receiver 60%%, both 12%%, long receiver hold");
    if (fail_count == 0 && pending_normals == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
